>>> sv/wrapped_bilinear_texture_sampler_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear texture sampler
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WRAPPED_BILINEAR_TEXTURE_SAMPLER_CORE_MACROS_SVH
`define WRAPPED_BILINEAR_TEXTURE_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WBTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbts assertion failed");
// next-cycle implication
`define WBTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbts assertion failed");
`else
`define WBTS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WBTS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/wbts_pkg.sv
// ----------------------------------------------------------------------------
// wbts_pkg
// Shared constants, codes and helpers of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package wbts_pkg;

   localparam int MAX_WIDTH_DEF   = 256;
   localparam int MAX_HEIGHT_DEF  = 256;
   localparam int WEIGHT_BITS_DEF = 8;
   localparam int MID_DEPTH_DEF   = 16;
   localparam int OUT_DEPTH_DEF   = 8;

   localparam int CFG_W   = 9;
   localparam int POS_W   = 32;
   localparam int FRAC_W  = 16;
   localparam int CHAN_W  = 8;
   localparam int TEXEL_W = 32;
   localparam int OUT_W   = 16;
   localparam int NIB_W   = 4;
   localparam int NUM_TAP = 4;

   typedef enum logic [1:0] {
      CMD_LOAD     = 2'd0,
      CMD_BILINEAR = 2'd1,
      CMD_NEAREST  = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int maxv);
      if (v == '0) begin
         return CFG_W'(1);
      end
      if (int'(v) > maxv) begin
         return CFG_W'(maxv);
      end
      return v;
   endfunction

endpackage

>>> sv/wbts_ram.sv
// ----------------------------------------------------------------------------
// wbts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wbts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/wbts_fifo.sv
// ----------------------------------------------------------------------------
// wbts_fifo
// Small register queue; callers guarantee no push when full, no pop when empty.
// ----------------------------------------------------------------------------
`include "wrapped_bilinear_texture_sampler_core_macros.svh"
module wbts_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   // credit schemes upstream must keep these
   `WBTS_ASSERT_IMP(a_no_overflow, clock, reset, push, count_ff != CNT_W'(DEPTH))
   `WBTS_ASSERT_IMP(a_no_underflow, clock, reset, pop, count_ff != '0)
   `WBTS_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

>>> sv/wbts_front.sv
// ----------------------------------------------------------------------------
// wbts_front
// Accepts and classifies transactions, scales and floors positions, wraps
// them through a pipelined modulo and emits texel addresses and weights.
// ----------------------------------------------------------------------------
module wbts_front import wbts_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int MID_DEPTH   = MID_DEPTH_DEF,
   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
   localparam int MID_W = 1 + NUM_TAP * AW + TEXEL_W + 2 * WEIGHT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              cmd,
   input  logic signed [POS_W-1:0] pos_x,
   input  logic signed [POS_W-1:0] pos_y,
   input  logic                    normalized,
   input  logic [7:0]              load_col,
   input  logic [7:0]              load_row,
   input  logic [CHAN_W-1:0]       texel_b,
   input  logic [CHAN_W-1:0]       texel_g,
   input  logic [CHAN_W-1:0]       texel_r,
   input  logic [CHAN_W-1:0]       texel_a,
   input  logic [CFG_W-1:0]        width_in_use,
   input  logic [CFG_W-1:0]        height_in_use,
   input  logic                    mid_pop,
   output logic                    mid_push,
   output logic [MID_W-1:0]        mid_data
);

   localparam int PW    = POS_W + CFG_W + 1;
   localparam int IW    = PW - FRAC_W;
   localparam int NSTG  = (IW + NIB_W - 1) / NIB_W;
   localparam int MP    = NSTG * NIB_W;
   localparam int OCC_W = $clog2(MID_DEPTH + 1);
   localparam int WB    = WEIGHT_BITS;

   typedef struct packed {
      logic                     is_load;
      logic [NUM_TAP-1:0][AW-1:0] addr;
      logic [TEXEL_W-1:0]       data;
      logic [WB-1:0]            fx;
      logic [WB-1:0]            fy;
   } mid_type;

   typedef struct packed {
      logic                    valid;
      logic                    is_load;
      logic                    nearest;
      logic                    norm;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic [AW-1:0]           laddr;
      logic [TEXEL_W-1:0]      ldata;
   } s1_type;

   typedef struct packed {
      logic                 valid;
      logic                 is_load;
      logic                 nearest;
      logic signed [PW-1:0] mx;
      logic signed [PW-1:0] my;
      logic [AW-1:0]        laddr;
      logic [TEXEL_W-1:0]   ldata;
   } s2_type;

   typedef struct packed {
      logic               valid;
      logic               is_load;
      logic               nearest;
      logic [AW-1:0]      laddr;
      logic [TEXEL_W-1:0] ldata;
      logic [WB-1:0]      fx;
      logic [WB-1:0]      fy;
      logic               neg_x;
      logic               neg_y;
      logic [MP-1:0]      mag_x;
      logic [MP-1:0]      mag_y;
      logic [CFG_W-1:0]   rem_x;
      logic [CFG_W-1:0]   rem_y;
   } mg_type;

   // four restoring remainder steps, one dividend bit each
   function automatic logic [CFG_W-1:0] mod_nib(input logic [CFG_W-1:0] rem,
                                                input logic [NIB_W-1:0] nib,
                                                input logic [CFG_W-1:0] m);
      logic [CFG_W:0]   t;
      logic [CFG_W-1:0] r;
      r = rem;
      for (int i = NIB_W - 1; i >= 0; i--) begin
         t = {r, nib[i]};
         if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
         end
         r = t[CFG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [CFG_W-1:0] row,
                                             input logic [CFG_W-1:0] col);
      return AW'(int'(row) * MAX_WIDTH + int'(col));
   endfunction

   // positive modulo from magnitude remainder
   function automatic logic [CFG_W-1:0] wrap_fix(input logic neg,
                                                 input logic [CFG_W-1:0] rem,
                                                 input logic [CFG_W-1:0] m);
      return (neg && rem != '0) ? m - rem : rem;
   endfunction

   function automatic logic [CFG_W-1:0] next_wrap(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] m);
      return (({1'b0, v} + 1'b1) == {1'b0, m}) ? '0 : v + 1'b1;
   endfunction

   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;
   mg_type           mg_ff [NSTG+1];
   mg_type           mg_in [NSTG+1];
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             accept;
   logic             keep;

   logic signed [PW-1:0] px_ext, py_ext, wx_ext, hy_ext;
   logic [IW-1:0]        floor_x, floor_y, mag_x, mag_y;

   logic [CFG_W-1:0] x0, x1, y0, y1;
   mid_type          mid;

   assign accept = push && !full;
   assign full   = occ_ff == OCC_W'(MID_DEPTH);

   // valid bits clear while reset is high
   always_comb begin
      case (cmd_type'(cmd))
         CMD_LOAD:     keep = (int'(load_col) < MAX_WIDTH) && (int'(load_row) < MAX_HEIGHT);
         CMD_BILINEAR: keep = 1'b1;
         CMD_NEAREST:  keep = 1'b1;
         default:      keep = 1'b0;
      endcase
      s1_in.valid   = accept && keep && !reset;
      s1_in.is_load = cmd == CMD_LOAD;
      s1_in.nearest = cmd == CMD_NEAREST;
      s1_in.norm    = normalized && (cmd == CMD_BILINEAR);
      s1_in.px      = pos_x;
      s1_in.py      = pos_y;
      s1_in.laddr   = AW'(int'(load_row) * MAX_WIDTH + int'(load_col));
      s1_in.ldata   = {texel_a, texel_r, texel_g, texel_b};
   end

   // scale by texture size when normalized
   always_comb begin
      px_ext = $signed({{(PW-POS_W){s1_ff.px[POS_W-1]}}, s1_ff.px});
      py_ext = $signed({{(PW-POS_W){s1_ff.py[POS_W-1]}}, s1_ff.py});
      wx_ext = $signed({{(PW-CFG_W){1'b0}}, width_in_use});
      hy_ext = $signed({{(PW-CFG_W){1'b0}}, height_in_use});
      s2_in.valid   = s1_ff.valid && !reset;
      s2_in.is_load = s1_ff.is_load;
      s2_in.nearest = s1_ff.nearest;
      s2_in.mx      = s1_ff.norm ? px_ext * wx_ext : px_ext;
      s2_in.my      = s1_ff.norm ? py_ext * hy_ext : py_ext;
      s2_in.laddr   = s1_ff.laddr;
      s2_in.ldata   = s1_ff.ldata;
   end

   // floor, sign and magnitude
   always_comb begin
      floor_x = s2_ff.mx[PW-1:FRAC_W];
      floor_y = s2_ff.my[PW-1:FRAC_W];
      mag_x   = floor_x[IW-1] ? -floor_x : floor_x;
      mag_y   = floor_y[IW-1] ? -floor_y : floor_y;
      mg_in[0].valid   = s2_ff.valid && !reset;
      mg_in[0].is_load = s2_ff.is_load;
      mg_in[0].nearest = s2_ff.nearest;
      mg_in[0].laddr   = s2_ff.laddr;
      mg_in[0].ldata   = s2_ff.ldata;
      mg_in[0].fx      = s2_ff.nearest ? '0 : s2_ff.mx[FRAC_W-1 -: WB];
      mg_in[0].fy      = s2_ff.nearest ? '0 : s2_ff.my[FRAC_W-1 -: WB];
      mg_in[0].neg_x   = floor_x[IW-1];
      mg_in[0].neg_y   = floor_y[IW-1];
      mg_in[0].mag_x   = MP'(mag_x);
      mg_in[0].mag_y   = MP'(mag_y);
      mg_in[0].rem_x   = '0;
      mg_in[0].rem_y   = '0;
      for (int k = 0; k < NSTG; k++) begin
         mg_in[k+1]       = mg_ff[k];
         mg_in[k+1].valid = mg_ff[k].valid && !reset;
         mg_in[k+1].rem_x = mod_nib(mg_ff[k].rem_x, mg_ff[k].mag_x[MP-1 -: NIB_W],
                                    width_in_use);
         mg_in[k+1].rem_y = mod_nib(mg_ff[k].rem_y, mg_ff[k].mag_y[MP-1 -: NIB_W],
                                    height_in_use);
         mg_in[k+1].mag_x = mg_ff[k].mag_x << NIB_W;
         mg_in[k+1].mag_y = mg_ff[k].mag_y << NIB_W;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      for (int k = 0; k <= NSTG; k++) begin
         mg_ff[k] <= mg_in[k];
      end
   end

   // wrapped neighbors and store addresses
   always_comb begin
      x0 = wrap_fix(mg_ff[NSTG].neg_x, mg_ff[NSTG].rem_x, width_in_use);
      y0 = wrap_fix(mg_ff[NSTG].neg_y, mg_ff[NSTG].rem_y, height_in_use);
      x1 = next_wrap(x0, width_in_use);
      y1 = next_wrap(y0, height_in_use);
      mid.is_load = mg_ff[NSTG].is_load;
      mid.data    = mg_ff[NSTG].ldata;
      mid.fx      = mg_ff[NSTG].fx;
      mid.fy      = mg_ff[NSTG].fy;
      if (mg_ff[NSTG].is_load) begin
         mid.addr = {NUM_TAP{mg_ff[NSTG].laddr}};
      end else if (mg_ff[NSTG].nearest) begin
         mid.addr = {NUM_TAP{addr_of(y0, x0)}};
      end else begin
         mid.addr = {addr_of(y1, x1), addr_of(y1, x0), addr_of(y0, x1), addr_of(y0, x0)};
      end
   end

   assign mid_push = mg_ff[NSTG].valid;
   assign mid_data = mid;

   // items in flight plus items queued never exceed the queue depth
   assign occ_in = occ_ff + OCC_W'(s1_in.valid) - OCC_W'(mid_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

>>> sv/wbts_back.sv
// ----------------------------------------------------------------------------
// wbts_back
// Writes loads into four replicated texel banks, reads four neighbors per
// sample, blends across x then y and queues the results.
// ----------------------------------------------------------------------------
module wbts_back import wbts_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int OUT_DEPTH   = OUT_DEPTH_DEF,
   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
   localparam int MID_W = 1 + NUM_TAP * AW + TEXEL_W + 2 * WEIGHT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              mid_empty,
   input  logic [MID_W-1:0]  mid_head,
   output logic              mid_pop,
   output logic              empty,
   input  logic              pop,
   output logic [OUT_W-1:0]  out_b,
   output logic [OUT_W-1:0]  out_g,
   output logic [OUT_W-1:0]  out_r,
   output logic [OUT_W-1:0]  out_a
);

   localparam int WB    = WEIGHT_BITS;
   localparam int TW    = CHAN_W + WB;
   localparam int SW    = CHAN_W + 2 * WB;
   localparam int CR_W  = $clog2(OUT_DEPTH + 1);
   localparam int RES_W = NUM_TAP * OUT_W;

   typedef struct packed {
      logic                       is_load;
      logic [NUM_TAP-1:0][AW-1:0] addr;
      logic [TEXEL_W-1:0]         data;
      logic [WB-1:0]              fx;
      logic [WB-1:0]              fy;
   } mid_type;

   mid_type                          head;
   logic [NUM_TAP-1:0][TEXEL_W-1:0]  texel;
   logic [CR_W-1:0]                  credit_ff, credit_in;
   logic                             b1_valid_ff, b2_valid_ff, b3_valid_ff;
   logic [WB-1:0]                    b1_fx_ff, b1_fy_ff, b2_fy_ff;
   logic [NUM_TAP-1:0][TW-1:0]       top_ff, top_in, bot_ff, bot_in;
   logic [NUM_TAP-1:0][SW-1:0]       sum_ff, sum_in;
   logic [TW-1:0]                    wx0, wx1, wy0, wy1;
   logic [RES_W-1:0]                 res_data, res_head;
   logic [CR_W-1:0]                  res_count;
   logic                             rsp_take;

   assign head     = mid_head;
   assign rsp_take = pop && !empty;
   // a sample leaves the mid queue only with a result slot reserved
   assign mid_pop  = !mid_empty && (credit_ff != CR_W'(OUT_DEPTH));

   for (genvar i = 0; i < NUM_TAP; i++) begin : g_bank
      wbts_ram #(
         .WIDTH(TEXEL_W),
         .DEPTH(MAX_WIDTH * MAX_HEIGHT)
      ) u_bank (
         .clock  (clock),
         .wr_en  (mid_pop && head.is_load),
         .wr_addr(head.addr[0]),
         .wr_data(head.data),
         .rd_addr(head.addr[i]),
         .rd_data(texel[i])
      );
   end

   // taps: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
   always_comb begin
      wx1 = TW'(b1_fx_ff);
      wx0 = TW'(1 << WB) - wx1;
      for (int c = 0; c < NUM_TAP; c++) begin
         top_in[c] = TW'(texel[0][c*CHAN_W +: CHAN_W]) * wx0
                   + TW'(texel[1][c*CHAN_W +: CHAN_W]) * wx1;
         bot_in[c] = TW'(texel[2][c*CHAN_W +: CHAN_W]) * wx0
                   + TW'(texel[3][c*CHAN_W +: CHAN_W]) * wx1;
      end
   end

   always_comb begin
      wy1 = TW'(b2_fy_ff);
      wy0 = TW'(1 << WB) - wy1;
      for (int c = 0; c < NUM_TAP; c++) begin
         sum_in[c] = SW'(top_ff[c]) * SW'(wy0) + SW'(bot_ff[c]) * SW'(wy1);
      end
   end

   always_ff @(posedge clock) begin
      b1_fx_ff <= head.fx;
      b1_fy_ff <= head.fy;
      top_ff   <= top_in;
      bot_ff   <= bot_in;
      b2_fy_ff <= b1_fy_ff;
      sum_ff   <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         credit_ff   <= '0;
      end else begin
         b1_valid_ff <= mid_pop && !head.is_load;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         credit_ff   <= credit_in;
      end
   end

   assign credit_in = credit_ff + CR_W'(mid_pop && !head.is_load) - CR_W'(rsp_take);

   always_comb begin
      for (int c = 0; c < NUM_TAP; c++) begin
         res_data[c*OUT_W +: OUT_W] = sum_ff[c][2*WB+CHAN_W-1 -: OUT_W];
      end
   end

   wbts_fifo #(
      .WIDTH(RES_W),
      .DEPTH(OUT_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (b3_valid_ff),
      .push_data(res_data),
      .pop      (rsp_take),
      .head     (res_head),
      .count    (res_count)
   );

   assign empty = res_count == '0;
   assign out_b = res_head[0*OUT_W +: OUT_W];
   assign out_g = res_head[1*OUT_W +: OUT_W];
   assign out_r = res_head[2*OUT_W +: OUT_W];
   assign out_a = res_head[3*OUT_W +: OUT_W];

endmodule

>>> sv/wrapped_bilinear_texture_sampler_core.sv
// ----------------------------------------------------------------------------
// wrapped_bilinear_texture_sampler_core
// Texture sampler with wrap addressing. Load transactions write BGRA8 texels;
// bilinear and nearest sample transactions each return one color, channels
// scaled by 256. One transaction is accepted per clock while full is low. A
// sample passes the front (input register, position scaling multiplier,
// floor, and a seven-stage modulo pipeline that retires four dividend bits
// per stage per axis), then the mid queue, then the back (bank read, x
// blend, y blend, result queue). Four replicated texel banks serve the four
// neighbor reads together; every load writes all four. The texture store
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module wrapped_bilinear_texture_sampler_core import wbts_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              req_cmd,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic                    req_normalized,
   input  logic [7:0]              req_load_col,
   input  logic [7:0]              req_load_row,
   input  logic [CHAN_W-1:0]       req_texel_b,
   input  logic [CHAN_W-1:0]       req_texel_g,
   input  logic [CHAN_W-1:0]       req_texel_r,
   input  logic [CHAN_W-1:0]       req_texel_a,
   output logic                    empty,
   input  logic                    pop,
   output logic [OUT_W-1:0]        rsp_out_b,
   output logic [OUT_W-1:0]        rsp_out_g,
   output logic [OUT_W-1:0]        rsp_out_r,
   output logic [OUT_W-1:0]        rsp_out_a,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int MID_W = 1 + NUM_TAP * AW + TEXEL_W + 2 * WEIGHT_BITS;
   localparam int MC_W  = $clog2(MID_DEPTH_DEF + 1);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             mid_push, mid_pop;
   logic [MID_W-1:0] mid_data, mid_head;
   logic [MC_W-1:0]  mid_count;

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_index_type'(paddr[2]))
            REG_WIDTH:  width_in  = clamp_size(pwdata[CFG_W-1:0], MAX_WIDTH);
            REG_HEIGHT: height_in = clamp_size(pwdata[CFG_W-1:0], MAX_HEIGHT);
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_size(CFG_W'(256), MAX_WIDTH);
         height_ff <= clamp_size(CFG_W'(256), MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = 32'(paddr[2] ? height_ff : width_ff);

   wbts_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WEIGHT_BITS(WEIGHT_BITS),
      .MID_DEPTH  (MID_DEPTH_DEF)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .cmd          (req_cmd),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .normalized   (req_normalized),
      .load_col     (req_load_col),
      .load_row     (req_load_row),
      .texel_b      (req_texel_b),
      .texel_g      (req_texel_g),
      .texel_r      (req_texel_r),
      .texel_a      (req_texel_a),
      .width_in_use (width_ff),
      .height_in_use(height_ff),
      .mid_pop      (mid_pop),
      .mid_push     (mid_push),
      .mid_data     (mid_data)
   );

   wbts_fifo #(
      .WIDTH(MID_W),
      .DEPTH(MID_DEPTH_DEF)
   ) u_mid_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (mid_push),
      .push_data(mid_data),
      .pop      (mid_pop),
      .head     (mid_head),
      .count    (mid_count)
   );

   wbts_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WEIGHT_BITS(WEIGHT_BITS),
      .OUT_DEPTH  (OUT_DEPTH_DEF)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mid_empty(mid_count == '0),
      .mid_head (mid_head),
      .mid_pop  (mid_pop),
      .empty    (empty),
      .pop      (pop),
      .out_b    (rsp_out_b),
      .out_g    (rsp_out_g),
      .out_r    (rsp_out_r),
      .out_a    (rsp_out_a)
   );

endmodule
